>>> rtl/lie_pkg.sv
// shared types and constants for the lagrange interpolation evaluator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lie_pkg;

   localparam int MAX_NODES_DEFAULT = 32;
   localparam int DATA_W            = 32;
   localparam int TERM_W            = 54;
   // |term| * |num| + |den|/2 stays below 2^87
   localparam int PROD_W            = 87;

   localparam logic [TERM_W-1:0] TERM_MAX = {TERM_W{1'b1}};

   typedef enum logic [1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_EVAL   = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_NODES = 2'd1,
      ST_DUP_X    = 2'd2,
      ST_DROPPED  = 2'd3
   } status_type;

endpackage

`default_nettype wire

>>> rtl/lie_if.sv
// valid/ready channel interfaces for the request and response beats
// depends on lie_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lie_req_if;
   logic                     valid;
   logic                     ready;
   lie_pkg::func_type        func;
   logic signed [31:0]       node_x;
   logic signed [31:0]       node_y;
   logic signed [31:0]       point_x;

   modport source (output valid, func, node_x, node_y, point_x, input ready);
   modport sink   (input valid, func, node_x, node_y, point_x, output ready);
endinterface

interface lie_rsp_if;
   logic                     valid;
   logic                     ready;
   logic signed [31:0]       value;
   lie_pkg::status_type      status;
   logic                     saturated;

   modport source (output valid, value, status, saturated, input ready);
   modport sink   (input valid, value, status, saturated, output ready);
endinterface

`default_nettype wire

>>> rtl/lagrange_interpolation_eval_unit.sv
// lagrange interpolation evaluator: node store, duplicate scan, serial term datapath
// depends on lie_pkg and lie_if
//
//   channel   dir   payload                              beat moves when
//   req_bus   in    func, node_x, node_y, point_x        valid && ready
//   rsp_bus   out   value, status, saturated             valid && ready
//
// append and clear finish in idle without leaving it. evaluate with n nodes
// runs a duplicate scan over the node pairs, then a multiply and a divide
// per (i, j) pair and an accumulate per node; the one-bit-per-cycle
// restoring divider (87 steps per factor) is the longest part of each pair.
// reset is synchronous and empties the node set; the stores need no clearing.
// req_ready is high only in idle; a finished result waits in the output
// register while the next beat is taken, and evaluation holds before its
// result while the previous one is still stalled.
`timescale 1ns / 1ps
`default_nettype none

module lagrange_interpolation_eval_unit #(
   parameter int MAX_NODES = lie_pkg::MAX_NODES_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   lie_req_if.sink   req_bus,
   lie_rsp_if.source rsp_bus
);
   import lie_pkg::*;

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int DW = $clog2(PROD_W + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DUP_RD, S_DUP_CMP, S_T_LOAD, S_T_INIT, S_J_RD, S_J_SUB,
      S_J_MUL_LO, S_J_MUL_HI, S_J_SUM, S_DIV, S_J_DONE, S_ACC, S_RESULT
   } state_type;

   state_type state_ff;

   // node stores, one write port and registered reads
   logic [DATA_W-1:0] x_mem [MAX_NODES];
   logic [DATA_W-1:0] y_mem [MAX_NODES];
   logic [DATA_W-1:0] xa_ff, xb_ff, ya_ff;

   logic [CW-1:0]       count_ff, i_ff, j_ff;
   logic                overflow_ff;
   logic [DATA_W-1:0]   px_ff, xi_ff;
   logic [TERM_W-1:0]   m_ff, q_ff;
   logic                neg_ff, sign_ff, big_ff;
   logic [31:0]         nm_ff, den_ff, rem_ff;
   logic [63:0]         plo_ff;
   logic [53:0]         phi_ff;
   logic [PROD_W-1:0]   dvd_ff;
   logic [DW-1:0]       div_cnt_ff;
   logic signed [63:0]  acc_ff;
   status_type          status_ff;

   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_value_ff;
   status_type          rsp_status_ff;
   logic                rsp_sat_ff;

   logic req_fire;
   logic mem_we;
   assign req_fire = req_bus.valid && (state_ff == S_IDLE);
   assign mem_we   = req_fire && (req_bus.func == FUNC_APPEND) &&
                     (count_ff < CW'(MAX_NODES));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         x_mem[count_ff[AW-1:0]] <= req_bus.node_x;
         y_mem[count_ff[AW-1:0]] <= req_bus.node_y;
      end
      xa_ff <= x_mem[i_ff[AW-1:0]];
      xb_ff <= x_mem[j_ff[AW-1:0]];
      ya_ff <= y_mem[i_ff[AW-1:0]];
   end

   // differences against x_j, taken exactly in 33 bits
   logic [32:0] num_s, den_s, num_mag, den_mag;
   assign num_s   = {px_ff[31], px_ff} - {xb_ff[31], xb_ff};
   assign den_s   = {xi_ff[31], xi_ff} - {xb_ff[31], xb_ff};
   assign num_mag = num_s[32] ? (~num_s + 33'd1) : num_s;
   assign den_mag = den_s[32] ? (~den_s + 33'd1) : den_s;

   // restoring divider step
   logic [32:0]       rem_sh, rem_in;
   logic              q_bit;
   assign rem_sh = {rem_ff, dvd_ff[PROD_W-1]};
   assign q_bit  = rem_sh >= {1'b0, den_ff};
   assign rem_in = q_bit ? (rem_sh - {1'b0, den_ff}) : rem_sh;

   logic [31:0] y_mag;
   assign y_mag = ya_ff[31] ? (~ya_ff + 32'd1) : ya_ff;

   logic signed [63:0] term;
   assign term = $signed({10'd0, m_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in S_RESULT the output register is handled below
         if (rsp_valid_ff && rsp_bus.ready && (state_ff != S_RESULT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_bus.valid) begin
                  case (req_bus.func)
                     FUNC_APPEND: begin
                        if (count_ff < CW'(MAX_NODES)) begin
                           count_ff <= count_ff + CW'(1);
                        end else begin
                           overflow_ff <= 1'b1;
                        end
                     end
                     FUNC_CLEAR: begin
                        count_ff    <= '0;
                        overflow_ff <= 1'b0;
                     end
                     FUNC_EVAL: begin
                        px_ff  <= req_bus.point_x;
                        acc_ff <= '0;
                        i_ff   <= '0;
                        j_ff   <= CW'(1);
                        if (count_ff == '0) begin
                           status_ff <= ST_NO_NODES;
                           state_ff  <= S_RESULT;
                        end else if (count_ff == CW'(1)) begin
                           state_ff <= S_T_LOAD;
                        end else begin
                           state_ff <= S_DUP_RD;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_DUP_RD: begin
               state_ff <= S_DUP_CMP;
            end
            S_DUP_CMP: begin
               if (xa_ff == xb_ff) begin
                  status_ff <= ST_DUP_X;
                  state_ff  <= S_RESULT;
               end else if ((j_ff + CW'(1)) < count_ff) begin
                  j_ff     <= j_ff + CW'(1);
                  state_ff <= S_DUP_RD;
               end else if ((i_ff + CW'(2)) < count_ff) begin
                  i_ff     <= i_ff + CW'(1);
                  j_ff     <= i_ff + CW'(2);
                  state_ff <= S_DUP_RD;
               end else begin
                  i_ff     <= '0;
                  state_ff <= S_T_LOAD;
               end
            end
            S_T_LOAD: begin
               state_ff <= S_T_INIT;
            end
            S_T_INIT: begin
               xi_ff    <= xa_ff;
               m_ff     <= {22'd0, y_mag};
               neg_ff   <= ya_ff[31];
               j_ff     <= '0;
               state_ff <= S_J_RD;
            end
            S_J_RD: begin
               // a zero magnitude stays zero, so the product stops early
               if ((j_ff == count_ff) || (m_ff == '0)) begin
                  state_ff <= S_ACC;
               end else if (j_ff == i_ff) begin
                  j_ff <= j_ff + CW'(1);
               end else begin
                  state_ff <= S_J_SUB;
               end
            end
            S_J_SUB: begin
               nm_ff    <= num_mag[31:0];
               den_ff   <= den_mag[31:0];
               sign_ff  <= num_s[32] ^ den_s[32];
               state_ff <= S_J_MUL_LO;
            end
            S_J_MUL_LO: begin
               plo_ff   <= 64'(m_ff[31:0]) * 64'(nm_ff);
               state_ff <= S_J_MUL_HI;
            end
            S_J_MUL_HI: begin
               phi_ff   <= 54'(m_ff[53:32]) * 54'(nm_ff);
               state_ff <= S_J_SUM;
            end
            S_J_SUM: begin
               // add half the divisor for round to nearest
               dvd_ff     <= {23'd0, plo_ff} + {1'b0, phi_ff, 32'd0} +
                             {56'd0, den_ff[31:1]};
               rem_ff     <= '0;
               q_ff       <= '0;
               big_ff     <= 1'b0;
               div_cnt_ff <= DW'(PROD_W);
               state_ff   <= S_DIV;
            end
            S_DIV: begin
               dvd_ff     <= {dvd_ff[PROD_W-2:0], 1'b0};
               rem_ff     <= rem_in[31:0];
               q_ff       <= {q_ff[TERM_W-2:0], q_bit};
               big_ff     <= big_ff | q_ff[TERM_W-1];
               div_cnt_ff <= div_cnt_ff - DW'(1);
               if (div_cnt_ff == DW'(1)) begin
                  state_ff <= S_J_DONE;
               end
            end
            S_J_DONE: begin
               m_ff     <= big_ff ? TERM_MAX : q_ff;
               neg_ff   <= neg_ff ^ sign_ff;
               j_ff     <= j_ff + CW'(1);
               state_ff <= S_J_RD;
            end
            S_ACC: begin
               acc_ff <= acc_ff + (neg_ff ? -term : term);
               i_ff   <= i_ff + CW'(1);
               if ((i_ff + CW'(1)) == count_ff) begin
                  status_ff <= overflow_ff ? ST_DROPPED : ST_OK;
                  state_ff  <= S_RESULT;
               end else begin
                  state_ff <= S_T_LOAD;
               end
            end
            S_RESULT: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  if (acc_ff > 64'sd2147483647) begin
                     rsp_value_ff <= 32'h7fff_ffff;
                     rsp_sat_ff   <= 1'b1;
                  end else if (acc_ff < -64'sd2147483648) begin
                     rsp_value_ff <= 32'h8000_0000;
                     rsp_sat_ff   <= 1'b1;
                  end else begin
                     rsp_value_ff <= acc_ff[31:0];
                     rsp_sat_ff   <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_bus.ready     = (state_ff == S_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.value     = rsp_value_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.saturated = rsp_sat_ff;

endmodule

`default_nettype wire

>>> rtl/lie_checker.sv
// port-level assertions for the lagrange interpolation evaluator, bound to the top
// depends on lie_pkg and lagrange_interpolation_eval_unit
`timescale 1ns / 1ps
`default_nettype none

module lie_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic signed [31:0]  rsp_value,
   input wire lie_pkg::status_type rsp_status,
   input wire logic                rsp_saturated
);
   import lie_pkg::*;

   // a stalled response beat stays up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_value) && $stable(rsp_status))
      else $error("rsp payload changed while stalled");

   // error statuses carry a zero, unclipped value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NO_NODES || rsp_status == ST_DUP_X)
      |-> rsp_value == 32'sd0 && !rsp_saturated)
      else $error("error status with nonzero value");

   // a clipped value sits at one of the range limits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated
      |-> rsp_value == 32'sh7fff_ffff || rsp_value == 32'sh8000_0000)
      else $error("saturated value not at a limit");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind lagrange_interpolation_eval_unit lie_checker u_lie_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_value     (rsp_bus.value),
   .rsp_status    (rsp_bus.status),
   .rsp_saturated (rsp_bus.saturated)
);

`default_nettype wire
